// ----- hw/rtl/q2e_pkg.sv -----
// q2e_pkg: shared constants, types and helpers for the quaternion to euler block
// depends on nothing; imported by every q2e module
package q2e_pkg;

  localparam int COMP_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ISQ_STAGES   = 29;
  localparam int V_W          = 38;
  localparam int Z_W          = 35;
  localparam int S_W          = 30;
  localparam int N_W          = 58;
  localparam int ROOT_W       = 29;
  localparam int FRONT_STAGES = 3;
  localparam int LATENCY      = FRONT_STAGES + ISQ_STAGES + 1 + CORDIC_STEPS + 1;

  localparam int SH_R = (COMP_W >= 16) ? COMP_W - 16 : 0;
  localparam int SH_L = (COMP_W >= 16) ? 0 : 16 - COMP_W;

  localparam logic signed [V_W-1:0] ONE_Q28 = V_W'(64'sd268435456);
  localparam logic signed [Z_W-1:0] PI_Q30  = Z_W'(64'sd3373259426);
  localparam logic signed [Z_W-1:0] ROUND_Q = Z_W'(64'sd65536);
  localparam logic signed [Z_W-1:0] LIM_PI  = Z_W'(64'sd25736);
  localparam logic signed [Z_W-1:0] LIM_HPI = Z_W'(64'sd12868);

  localparam logic [31:0] ATAN_TABLE [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [V_W-1:0] yn;
    logic signed [V_W-1:0] yd;
    logic signed [V_W-1:0] rn;
    logic signed [V_W-1:0] rd;
    logic signed [S_W-1:0] s;
    logic                  clamped;
  } side_t;

  function automatic logic signed [15:0] to_q14(input logic signed [COMP_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    e = (e >>> SH_R) <<< SH_L;
    return e[15:0];
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [Z_W-1:0] z,
                                                   input logic signed [Z_W-1:0] lim);
    logic signed [Z_W-1:0] r;
    r = (z + ROUND_Q) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

// ----- hw/rtl/q2e_front.sv -----
// q2e_front: products, sums with pitch clamp, and the radicand for the cosine
// depends on q2e_pkg
module q2e_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_w_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_x_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_y_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_z_i,
  output logic                              valid_o,
  output q2e_pkg::side_t                    side_o,
  output logic [q2e_pkg::N_W-1:0]           n_o
);
  import q2e_pkg::*;

  logic signed [15:0] w, x, y, z;
  logic signed [31:0] p_wz_q, p_xy_q, p_ww_q, p_xx_q, p_wx_q, p_yz_q, p_zz_q, p_wy_q, p_xz_q;
  logic [2:0] valid_q;
  side_t side2_d, side2_q, side3_q;
  logic signed [V_W-1:0] s_full;
  logic signed [2*S_W-1:0] sq;
  logic [N_W-1:0] n_d, n_q;

  assign w = to_q14(q_w_i);
  assign x = to_q14(q_x_i);
  assign y = to_q14(q_y_i);
  assign z = to_q14(q_z_i);

  always_comb begin
    side2_d.yn = (V_W'(p_wz_q) + V_W'(p_xy_q)) <<< 1;
    side2_d.yd = ((V_W'(p_ww_q) + V_W'(p_xx_q)) <<< 1) - ONE_Q28;
    side2_d.rn = (V_W'(p_wx_q) + V_W'(p_yz_q)) <<< 1;
    side2_d.rd = ((V_W'(p_ww_q) + V_W'(p_zz_q)) <<< 1) - ONE_Q28;
    s_full     = (V_W'(p_wy_q) - V_W'(p_xz_q)) <<< 1;
    side2_d.clamped = 1'b0;
    if (s_full > ONE_Q28) begin
      side2_d.s = S_W'(ONE_Q28);
      side2_d.clamped = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      side2_d.s = S_W'(-ONE_Q28);
      side2_d.clamped = 1'b1;
    end else begin
      side2_d.s = S_W'(s_full);
    end
  end

  assign sq  = side2_q.s * side2_q.s;
  assign n_d = (N_W'(1) << 56) - N_W'(sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_wz_q  <= w * z;
    p_xy_q  <= x * y;
    p_ww_q  <= w * w;
    p_xx_q  <= x * x;
    p_wx_q  <= w * x;
    p_yz_q  <= y * z;
    p_zz_q  <= z * z;
    p_wy_q  <= w * y;
    p_xz_q  <= x * z;
    side2_q <= side2_d;
    side3_q <= side2_q;
    n_q     <= n_d;
  end

  assign valid_o = valid_q[2];
  assign side_o  = side3_q;
  assign n_o     = n_q;
endmodule

// ----- hw/rtl/q2e_isqrt.sv -----
// q2e_isqrt: pipelined floor square root, one result bit per stage
// depends on q2e_pkg; carries the side operands along for alignment
module q2e_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [q2e_pkg::N_W-1:0]    n_i,
  input  q2e_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [q2e_pkg::ROOT_W-1:0] root_o,
  output q2e_pkg::side_t             side_o
);
  import q2e_pkg::*;

  logic [N_W-1:0] n_q [ISQ_STAGES];
  logic [N_W-1:0] r_q [ISQ_STAGES];
  side_t side_q [ISQ_STAGES];
  logic [ISQ_STAGES-1:0] valid_q;

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    localparam logic [N_W-1:0] BitK = N_W'(1) << (2 * (ISQ_STAGES - 1 - k));
    logic [N_W-1:0] n_in, r_in, trial;
    side_t side_in;
    logic v_in;
    if (k == 0) begin : g_first
      assign n_in    = n_i;
      assign r_in    = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign r_in    = r_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = valid_q[k-1];
    end
    assign trial = r_in + BitK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (n_in >= trial) begin
        n_q[k] <= n_in - trial;
        r_q[k] <= (r_in >> 1) + BitK;
      end else begin
        n_q[k] <= n_in;
        r_q[k] <= r_in >> 1;
      end
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[ISQ_STAGES-1];
  assign root_o  = r_q[ISQ_STAGES-1][ROOT_W-1:0];
  assign side_o  = side_q[ISQ_STAGES-1];
endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// q2e_cordic: unrolled vectoring cordic giving atan2(y, x) in Q5.30 radians
// depends on q2e_pkg for the angle table and widths
module q2e_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [q2e_pkg::V_W-1:0]    x_i,
  input  logic signed [q2e_pkg::V_W-1:0]    y_i,
  input  logic                              tag_i,
  output logic                              valid_o,
  output logic signed [q2e_pkg::Z_W-1:0]    z_o,
  output logic                              tag_o
);
  import q2e_pkg::*;

  logic signed [V_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [V_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] z_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] zero_q, tag_q, valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    tag_q[0]  <= tag_i;
    if (x_i < 0) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      z_q[0] <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [V_W-1:0] xs, ys;
    logic signed [Z_W-1:0] ang;
    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign ang = $signed(Z_W'(ATAN_TABLE[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      tag_q[i+1]  <= tag_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + ang;
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - ang;
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS];
  assign z_o     = zero_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];
  assign tag_o   = tag_q[CORDIC_STEPS];
endmodule

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// quaternion_to_euler_angles: unit quaternion to zyx euler angles, yaw and roll in Q3.13 radians, pitch in Q2.13
// start_i passes through the front, square root, cordic and output registers to valid_o
// throughput: one quaternion per cycle, busy_o stays low; the pipeline has no stall
// the rate is set by the unrolled square root and cordic stages, one step per stage
// reset clears only the valid bits; results appear as one-cycle strobes on valid_o
// depends on q2e_pkg, q2e_front, q2e_isqrt, q2e_cordic
module quaternion_to_euler_angles (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_w_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_x_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_y_i,
  input  logic signed [q2e_pkg::COMP_W-1:0] q_z_i,
  output logic                              valid_o,
  output logic signed [15:0]                yaw_angle_o,
  output logic signed [14:0]                pitch_angle_o,
  output logic signed [15:0]                roll_angle_o,
  output logic                              pitch_clamped_o
);
  import q2e_pkg::*;

  logic front_valid, sq_valid, v_yaw, v_pitch, v_roll, clamp_out;
  side_t front_side, sq_side;
  logic [N_W-1:0] front_n;
  logic [ROOT_W-1:0] root;
  logic signed [Z_W-1:0] z_yaw, z_pitch, z_roll;
  logic signed [15:0] yaw_d, pitch_d, roll_d;
  logic valid_q;
  logic signed [15:0] yaw_q, roll_q;
  logic signed [14:0] pitch_q;
  logic clamp_q;

  assign busy_o = 1'b0;

  q2e_front u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i & ~busy_o),
    .q_w_i, .q_x_i, .q_y_i, .q_z_i,
    .valid_o (front_valid),
    .side_o  (front_side),
    .n_o     (front_n)
  );

  q2e_isqrt u_isqrt (
    .clk_i, .rst_ni,
    .valid_i (front_valid),
    .n_i     (front_n),
    .side_i  (front_side),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  q2e_cordic u_yaw (
    .clk_i, .rst_ni,
    .valid_i (sq_valid), .x_i (sq_side.yd), .y_i (sq_side.yn), .tag_i (1'b0),
    .valid_o (v_yaw), .z_o (z_yaw), .tag_o ()
  );

  q2e_cordic u_pitch (
    .clk_i, .rst_ni,
    .valid_i (sq_valid),
    .x_i     ($signed(V_W'(root))),
    .y_i     (V_W'(sq_side.s)),
    .tag_i   (sq_side.clamped),
    .valid_o (v_pitch), .z_o (z_pitch), .tag_o (clamp_out)
  );

  q2e_cordic u_roll (
    .clk_i, .rst_ni,
    .valid_i (sq_valid), .x_i (sq_side.rd), .y_i (sq_side.rn), .tag_i (1'b0),
    .valid_o (v_roll), .z_o (z_roll), .tag_o ()
  );

  assign yaw_d   = round_sat(z_yaw, LIM_PI);
  assign pitch_d = round_sat(z_pitch, LIM_HPI);
  assign roll_d  = round_sat(z_roll, LIM_PI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v_yaw & v_pitch & v_roll;
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q   <= yaw_d;
    pitch_q <= pitch_d[14:0];
    roll_q  <= roll_d;
    clamp_q <= clamp_out;
  end

  assign valid_o         = valid_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_angle_o   = pitch_q;
  assign roll_angle_o    = roll_q;
  assign pitch_clamped_o = clamp_q;

`ifndef SYNTHESIS
  a_result_has_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LATENCY))
    else $error("result strobe without a matching input transfer");

  a_clamp_near_half_pi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pitch_clamped_o) |-> (pitch_angle_o > 15'sd12000 || pitch_angle_o < -15'sd12000))
    else $error("clamped pitch is not near plus or minus half pi");

  a_yaw_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (yaw_angle_o <= 16'sd25736 && yaw_angle_o >= -16'sd25736
                 && roll_angle_o <= 16'sd25736 && roll_angle_o >= -16'sd25736))
    else $error("yaw or roll beyond saturation limits");
`endif
endmodule
